[rtl/txw_pkg.sv]
// Package for the text word wrapper: payload types, character codes and step helpers.
package txw_pkg;

	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_HY = 8'h2D;

	localparam logic [7:0] WRAP_RESET = 8'd80;
	localparam logic [7:0] WRAP_MIN = 8'd3;
	localparam int QUEUE_DEPTH_DEF = 2;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        final_out;
		logic [15:0] row_count;
	} out_item_t;

	// What one character turns into on the output side.
	typedef enum logic [1:0] {
		OP_PLAIN,   // the character alone
		OP_CHAR_NL, // the character, then a newline
		OP_HYPH_NL, // hyphen, newline, then the character
		OP_NL_CHAR  // newline, then the character
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] ch;
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] col;
	} cls_t;

	// One queue entry: the work caused by one accepted item.
	typedef struct packed {
		op_t  op_a;
		op_t  op_b;
		logic b_valid;
		logic final_flag;
	} entry_t;

	function automatic logic word_char(input logic [7:0] c);
		return (c != CH_SP) && (c != CH_NL);
	endfunction

	// Decide how a character leaves, given its neighbors and the current column.
	function automatic cls_t classify(input logic [7:0] c, input logic [7:0] pre,
			input logic post_word, input logic [7:0] column, input logic [7:0] thr);
		cls_t r;
		r.op.ch = c;
		if (c == CH_NL) begin
			r.op.kind = OP_PLAIN;
			r.col = 8'd0;
		end else if (column >= thr) begin
			if (!word_char(c) || !post_word) begin
				r.op.kind = OP_CHAR_NL;
				r.col = 8'd0;
			end else if (word_char(pre)) begin
				r.op.kind = OP_HYPH_NL;
				r.col = 8'd1;
			end else begin
				r.op.kind = OP_NL_CHAR;
				r.col = 8'd1;
			end
		end else begin
			r.op.kind = OP_PLAIN;
			r.col = column + 8'd1;
		end
		return r;
	endfunction

	// Number of output bytes minus one for an operation.
	function automatic logic [1:0] op_last_idx(input op_kind_t k);
		logic [1:0] n;
		case (k)
			OP_PLAIN:   n = 2'd0;
			OP_CHAR_NL: n = 2'd1;
			OP_HYPH_NL: n = 2'd2;
			OP_NL_CHAR: n = 2'd1;
			default:    n = 2'd0;
		endcase
		return n;
	endfunction

	// Output byte at a given position within an operation.
	function automatic logic [7:0] op_byte(input op_t op, input logic [1:0] idx);
		logic [7:0] b;
		case (op.kind)
			OP_PLAIN:   b = op.ch;
			OP_CHAR_NL: b = (idx == 2'd0) ? op.ch : CH_NL;
			OP_HYPH_NL: b = (idx == 2'd0) ? CH_HY : ((idx == 2'd1) ? CH_NL : op.ch);
			OP_NL_CHAR: b = (idx == 2'd0) ? CH_NL : op.ch;
			default:    b = op.ch;
		endcase
		return b;
	endfunction

endpackage

[rtl/txw_front.sv]
// Front end: accepts text bytes, keeps the lookahead and column, classifies each byte.
module txw_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata,
	input  logic             accept,
	input  txw_pkg::in_item_t item,
	output logic             entry_push,
	output txw_pkg::entry_t  entry
);
	import txw_pkg::*;

	logic [7:0] wrap_width_q;
	logic [7:0] held_byte_q;
	logic       held_valid_q;
	logic [7:0] before_held_q;
	logic [7:0] column_q;

	logic [7:0] width_eff;
	logic [7:0] thr;
	logic [7:0] prev;
	logic [7:0] col_mid;
	cls_t       cls_held;
	cls_t       cls_new;

	// Threshold from the width register, with small widths acting as the minimum.
	assign width_eff = (wrap_width_q < WRAP_MIN) ? WRAP_MIN : wrap_width_q;
	assign thr = width_eff - 8'd1;

	// The held byte is judged first, then the new byte when it ends the text.
	always_comb begin
		cls_held = classify(held_byte_q, before_held_q, word_char(item.text_byte),
			column_q, thr);
		col_mid = held_valid_q ? cls_held.col : column_q;
		prev = held_valid_q ? held_byte_q : before_held_q;
		cls_new = classify(item.text_byte, prev, 1'b1, col_mid, thr);
	end

	// Build the queue entry for this transfer.
	always_comb begin
		entry_push = accept && (held_valid_q || item.end_of_text);
		entry.final_flag = item.end_of_text;
		if (held_valid_q) begin
			entry.op_a = cls_held.op;
			entry.op_b = cls_new.op;
			entry.b_valid = item.end_of_text;
		end else begin
			entry.op_a = cls_new.op;
			entry.op_b = cls_new.op;
			entry.b_valid = 1'b0;
		end
	end

	// Width register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_width_q <= WRAP_RESET;
		end else if (cfg_we) begin
			wrap_width_q <= cfg_wdata;
		end
	end

	// Text state: cleared at the end of each text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q <= 8'd0;
			held_valid_q <= 1'b0;
			before_held_q <= 8'd0;
			column_q <= 8'd0;
		end else if (accept) begin
			if (item.end_of_text) begin
				held_byte_q <= 8'd0;
				held_valid_q <= 1'b0;
				before_held_q <= 8'd0;
				column_q <= 8'd0;
			end else begin
				held_byte_q <= item.text_byte;
				held_valid_q <= 1'b1;
				before_held_q <= prev;
				column_q <= col_mid;
			end
		end
	end

endmodule

[rtl/txw_queue.sv]
// Short queue of classified entries between the front end and the back end.
module txw_queue #(
	parameter int DEPTH = txw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  txw_pkg::entry_t push_entry,
	output logic            full,
	output logic            head_valid,
	output txw_pkg::entry_t head,
	input  logic            pop
);
	import txw_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t         mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	logic do_push;
	logic do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[rtl/txw_back.sv]
// Back end: expands queue entries into output bytes and keeps the row count.
module txw_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  txw_pkg::entry_t    head,
	output logic               head_pop,
	output logic               empty,
	input  logic               pop,
	output txw_pkg::out_item_t result
);
	import txw_pkg::*;

	logic        phase_q;
	logic [1:0]  idx_q;
	logic [15:0] rows_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        load;
	op_t         cur_op;
	logic [7:0]  cur_byte;
	logic        last_in_op;
	logic        last_in_entry;
	logic        is_final;
	logic [15:0] rows_next;

	// Pick the byte for this position in the current entry.
	always_comb begin
		load = head_valid && (!out_valid_q || pop);
		cur_op = phase_q ? head.op_b : head.op_a;
		cur_byte = op_byte(cur_op, idx_q);
		last_in_op = (idx_q == op_last_idx(cur_op.kind));
		last_in_entry = last_in_op && (phase_q || !head.b_valid);
		is_final = last_in_entry && head.final_flag;
		rows_next = ((cur_byte == CH_NL) && (rows_q != 16'hFFFF)) ? rows_q + 16'd1 : rows_q;
		head_pop = load && last_in_entry;
	end

	assign empty = !out_valid_q;
	assign result = out_q;

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte <= cur_byte;
			out_q.final_out <= is_final;
			out_q.row_count <= rows_next;
		end
	end

	// Sequencing through the entry, output valid and row counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			idx_q <= 2'd0;
			rows_q <= 16'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				rows_q <= is_final ? 16'd1 : rows_next;
				if (last_in_entry) begin
					phase_q <= 1'b0;
					idx_q <= 2'd0;
				end else if (last_in_op) begin
					phase_q <= 1'b1;
					idx_q <= 2'd0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

endmodule

[rtl/text_word_wrapper_top.sv]
// Top level of the text word wrapper: front end, entry queue and back end.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+------------------------------------------
//  input    | push / full        | item   (text_byte, end_of_text)
//  result   | pop / empty        | result (out_byte, final_out, row_count)
//  config   | cfg_we             | cfg_wdata (wrap_width)
//
// The front end takes one input transfer per cycle while the entry queue has room.
// Each byte gives zero to three output bytes, a text's final byte up to six; the
// back end sends one result per cycle while popped, so the output side sets the rate.
// Results pass through the entry queue and then the back end's output register.
// Reset is asynchronous and immediate; there is no clearing pass.
module text_word_wrapper_top #(
	parameter int QUEUE_DEPTH = txw_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  txw_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output txw_pkg::out_item_t result,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata
);
	import txw_pkg::*;

	logic   accept;
	logic   entry_push;
	entry_t entry;
	logic   head_valid;
	entry_t head;
	logic   head_pop;

	assign accept = push && !full;

	txw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.accept     (accept),
		.item       (item),
		.entry_push (entry_push),
		.entry      (entry)
	);

	txw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (entry_push),
		.push_entry (entry),
		.full       (full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (head_pop)
	);

	txw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule
